// ----- sv/spdd_pkg.sv -----
`default_nettype none

package spdd_pkg;

    localparam int unsigned DigitCount = 10;
    localparam int unsigned PinLength  = 4;
    localparam int unsigned SeedWidth  = 32;
    localparam int unsigned CharWidth  = 8;
    localparam int unsigned DigitWidth = 4;
    localparam int unsigned CfgCount   = 2;
    localparam int unsigned CfgIdxWidth = $clog2(CfgCount);

    localparam logic [CharWidth-1:0] CharZero = 8'h30;
    localparam logic [CharWidth-1:0] CharNine = 8'h39;

    // last shuffle round, and the count at which its swap lands
    localparam logic [3:0] RoundLast = 4'd9;
    localparam logic [3:0] ShufDone  = 4'd10;

    localparam logic [SeedWidth-1:0] OffsetReset     = 32'h0088_1234;
    localparam logic [SeedWidth-1:0] MultiplierReset = 32'h0000_3498;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_SEED_OFFSET     = 1'b0,
        CFG_SEED_MULTIPLIER = 1'b1
    } cfg_idx_t;

    typedef logic [DigitWidth-1:0] digit_t;
    typedef logic [CharWidth-1:0]  char_t;

    // controller to datapath commands
    typedef struct packed {
        logic       load;
        logic       advance;
        logic       quot;
        logic [3:0] quot_round;
        logic       decode;
        logic [1:0] decode_idx;
        logic       publish;
    } cmd_t;

    // floor(2^32 / (round+1)), quotient estimate is then low by at most one
    function automatic logic [SeedWidth-1:0] recip(input logic [3:0] round);
        logic [SeedWidth-1:0] m;
        unique case (round)
            4'd1:    m = 32'h8000_0000;
            4'd2:    m = 32'h5555_5555;
            4'd3:    m = 32'h4000_0000;
            4'd4:    m = 32'h3333_3333;
            4'd5:    m = 32'h2AAA_AAAA;
            4'd6:    m = 32'h2492_4924;
            4'd7:    m = 32'h2000_0000;
            4'd8:    m = 32'h1C71_C71C;
            4'd9:    m = 32'h1999_9999;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- sv/spdd_ctrl.sv -----
`default_nettype none

module spdd_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    output spdd_pkg::cmd_t     cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHUF,
        S_DEC,
        S_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SHUF;
                    cnt_next   = '0;
                end
            end
            S_SHUF:
            begin
                cmd.advance    = (cnt_reg < spdd_pkg::RoundLast);
                cmd.quot       = (cnt_reg != '0) && (cnt_reg <= spdd_pkg::RoundLast);
                cmd.quot_round = cnt_reg;
                if (cnt_reg == spdd_pkg::ShufDone)
                begin
                    state_next = S_DEC;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            S_DEC:
            begin
                cmd.decode     = 1'b1;
                cmd.decode_idx = cnt_reg[1:0];
                if (cnt_reg == 4'(spdd_pkg::PinLength - 1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            S_DONE:
            begin
                // hand over once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- sv/spdd_datapath.sv -----
`default_nettype none

module spdd_datapath (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire spdd_pkg::cmd_t                       cmd,
    input  wire logic                                 cfg_write,
    input  wire logic [spdd_pkg::CfgIdxWidth-1:0]     cfg_index,
    input  wire logic [spdd_pkg::SeedWidth-1:0]       cfg_data,
    input  wire logic [spdd_pkg::SeedWidth-1:0]       session_seed,
    input  wire spdd_pkg::char_t                      char_first,
    input  wire spdd_pkg::char_t                      char_second,
    input  wire spdd_pkg::char_t                      char_third,
    input  wire spdd_pkg::char_t                      char_fourth,
    output spdd_pkg::digit_t                          digit_first,
    output spdd_pkg::digit_t                          digit_second,
    output spdd_pkg::digit_t                          digit_third,
    output spdd_pkg::digit_t                          digit_fourth
);

    logic [spdd_pkg::SeedWidth-1:0] seed_offset_reg;
    logic [spdd_pkg::SeedWidth-1:0] seed_multiplier_reg;
    logic [spdd_pkg::SeedWidth-1:0] seed_reg;

    spdd_pkg::char_t  char_reg  [spdd_pkg::PinLength];
    spdd_pkg::digit_t digit_reg [spdd_pkg::PinLength];
    spdd_pkg::digit_t out_reg   [spdd_pkg::PinLength];
    spdd_pkg::digit_t table_reg [spdd_pkg::DigitCount];

    // swap stage
    logic       sw_valid_reg;
    logic [3:0] sw_round_reg;
    logic [4:0] q5_reg;
    logic [4:0] x5_reg;

    logic [spdd_pkg::SeedWidth-1:0]   seed_step;
    logic [2*spdd_pkg::SeedWidth-1:0] quot_prod;
    logic [3:0]                       divisor;
    logic [9:0]                       qd_full;
    logic [4:0]                       rem_est;
    logic [4:0]                       rem_fix;
    logic [3:0]                       pos;
    spdd_pkg::char_t                  cur_char;
    logic                             is_digit;
    logic [3:0]                       rd_addr;
    spdd_pkg::digit_t                 rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_offset_reg     <= spdd_pkg::OffsetReset;
            seed_multiplier_reg <= spdd_pkg::MultiplierReset;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                spdd_pkg::CFG_SEED_OFFSET:     seed_offset_reg     <= cfg_data;
                spdd_pkg::CFG_SEED_MULTIPLIER: seed_multiplier_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign seed_step = seed_offset_reg + seed_reg * seed_multiplier_reg;

    // quotient estimate of seed / (round+1) by reciprocal, only low bits are kept
    assign quot_prod = 64'(seed_reg) * 64'(spdd_pkg::recip(cmd.quot_round));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            seed_reg <= session_seed;
        end
        else if (cmd.advance)
        begin
            seed_reg <= seed_step;
        end
        if (cmd.quot)
        begin
            q5_reg       <= quot_prod[spdd_pkg::SeedWidth +: 5];
            x5_reg       <= seed_reg[4:0];
            sw_round_reg <= cmd.quot_round;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_valid_reg <= 1'b0;
        end
        else
        begin
            sw_valid_reg <= cmd.quot;
        end
    end

    // remainder is below twice the divisor, so five bits and one fixup do
    assign divisor = sw_round_reg + 4'd1;
    assign qd_full = 10'(q5_reg) * 10'(divisor);
    assign rem_est = x5_reg - qd_full[4:0];
    assign rem_fix = (rem_est >= 5'(divisor)) ? (rem_est - 5'(divisor)) : rem_est;
    assign pos     = rem_fix[3:0];

    assign cur_char = char_reg[cmd.decode_idx];
    assign is_digit = (cur_char >= spdd_pkg::CharZero) && (cur_char <= spdd_pkg::CharNine);
    assign rd_addr  = cmd.decode ? (is_digit ? cur_char[3:0] : 4'd0) : pos;
    assign rd_data  = table_reg[rd_addr];

    // entry round still holds its own index here, so the swap needs one read
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < spdd_pkg::DigitCount; j++)
        begin
            if (cmd.load)
            begin
                table_reg[j] <= 4'(j);
            end
            else if (sw_valid_reg)
            begin
                if (4'(j) == sw_round_reg)
                begin
                    table_reg[j] <= rd_data;
                end
                else if (4'(j) == pos)
                begin
                    table_reg[j] <= sw_round_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            char_reg[0] <= char_first;
            char_reg[1] <= char_second;
            char_reg[2] <= char_third;
            char_reg[3] <= char_fourth;
        end
        if (cmd.decode)
        begin
            digit_reg[cmd.decode_idx] <= is_digit ? rd_data : '0;
        end
        if (cmd.publish)
        begin
            for (int k = 0; k < spdd_pkg::PinLength; k++)
            begin
                out_reg[k] <= digit_reg[k];
            end
        end
    end

    assign digit_first  = out_reg[0];
    assign digit_second = out_reg[1];
    assign digit_third  = out_reg[2];
    assign digit_fourth = out_reg[3];

endmodule

`default_nettype wire

// ----- sv/scrambled_pin_digit_decoder_unit.sv -----
// from input transfer to result valid: the shuffle, one lookup per character, the hand-off
// one item at a time, paced by the nine shuffle rounds through one seed multiplier and
// one swap port on the digit table, then one table read per character
// the finished result waits in an output register while the next item is taken
// reset: asynchronous active low, clears control and loads the register defaults
`default_nettype none

module scrambled_pin_digit_decoder_unit (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_write,
    input  wire logic [spdd_pkg::CfgIdxWidth-1:0]     cfg_index,
    input  wire logic [spdd_pkg::SeedWidth-1:0]       cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [spdd_pkg::SeedWidth-1:0]       session_seed,
    input  wire spdd_pkg::char_t                      char_first,
    input  wire spdd_pkg::char_t                      char_second,
    input  wire spdd_pkg::char_t                      char_third,
    input  wire spdd_pkg::char_t                      char_fourth,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output spdd_pkg::digit_t                          digit_first,
    output spdd_pkg::digit_t                          digit_second,
    output spdd_pkg::digit_t                          digit_third,
    output spdd_pkg::digit_t                          digit_fourth
);

    spdd_pkg::cmd_t cmd;

    spdd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    spdd_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .session_seed (session_seed),
        .char_first   (char_first),
        .char_second  (char_second),
        .char_third   (char_third),
        .char_fourth  (char_fourth),
        .digit_first  (digit_first),
        .digit_second (digit_second),
        .digit_third  (digit_third),
        .digit_fourth (digit_fourth)
    );

endmodule

`default_nettype wire

// ----- sv/spdd_checker.sv -----
`default_nettype none

module spdd_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_valid,
    input wire logic             in_ready,
    input wire logic             out_valid,
    input wire logic             out_ready,
    input wire spdd_pkg::digit_t digit_first,
    input wire spdd_pkg::digit_t digit_second,
    input wire spdd_pkg::digit_t digit_third,
    input wire spdd_pkg::digit_t digit_fourth
);

    // one item in flight: after an input transfer the block stops taking input
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while an item is in flight");

    // a new result appears only as the block frees its input side
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result shown while still busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped before transfer");

    // decoded values never leave the digit range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (digit_first <= 4'd9) && (digit_second <= 4'd9)
                   && (digit_third <= 4'd9) && (digit_fourth <= 4'd9))
        else $error("decoded digit out of range");

endmodule

bind scrambled_pin_digit_decoder_unit spdd_checker u_spdd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .digit_first  (digit_first),
    .digit_second (digit_second),
    .digit_third  (digit_third),
    .digit_fourth (digit_fourth)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
module tb_top;

    localparam int unsigned StallLimit  = 2000;
    localparam int unsigned DrainCycles = 20;
    localparam int unsigned MaxGap      = 30;

    typedef struct packed {
        spdd_pkg::digit_t digit_first;
        spdd_pkg::digit_t digit_second;
        spdd_pkg::digit_t digit_third;
        spdd_pkg::digit_t digit_fourth;
    } pin_digits_t;

    logic                             clk;
    logic                             rst_n        = 1'b0;
    logic                             cfg_write    = 1'b0;
    logic [spdd_pkg::CfgIdxWidth-1:0] cfg_index    = '0;
    logic [spdd_pkg::SeedWidth-1:0]   cfg_data     = '0;
    logic                             in_valid     = 1'b0;
    logic                             in_ready;
    logic [spdd_pkg::SeedWidth-1:0]   session_seed = '0;
    spdd_pkg::char_t                  char_first   = '0;
    spdd_pkg::char_t                  char_second  = '0;
    spdd_pkg::char_t                  char_third   = '0;
    spdd_pkg::char_t                  char_fourth  = '0;
    logic                             out_valid;
    logic                             out_ready    = 1'b0;
    spdd_pkg::digit_t                 digit_first;
    spdd_pkg::digit_t                 digit_second;
    spdd_pkg::digit_t                 digit_third;
    spdd_pkg::digit_t                 digit_fourth;

    // mirror of the block's registers
    logic [spdd_pkg::SeedWidth-1:0] offset_mirror     = spdd_pkg::OffsetReset;
    logic [spdd_pkg::SeedWidth-1:0] multiplier_mirror = spdd_pkg::MultiplierReset;

    pin_digits_t pending_digits[$];

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int error_count        = 0;
    int pins_sent          = 0;
    int pins_checked       = 0;
    int settings_used      = 1;
    int quiet_cycles       = 0;

    scrambled_pin_digit_decoder_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .session_seed (session_seed),
        .char_first   (char_first),
        .char_second  (char_second),
        .char_third   (char_third),
        .char_fourth  (char_fourth),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .digit_first  (digit_first),
        .digit_second (digit_second),
        .digit_third  (digit_third),
        .digit_fourth (digit_fourth)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // shuffle the digit table from the seed, then look up each character
    function automatic pin_digits_t unscramble_pin(
        input logic [spdd_pkg::SeedWidth-1:0]                 seed,
        input spdd_pkg::char_t [spdd_pkg::PinLength-1:0]      chars);
        logic [spdd_pkg::DigitCount-1:0][spdd_pkg::DigitWidth-1:0] perm;
        logic [spdd_pkg::SeedWidth-1:0]                            lcg;
        logic [spdd_pkg::SeedWidth-1:0]                            pos;
        spdd_pkg::digit_t                                          held;
        spdd_pkg::digit_t [spdd_pkg::PinLength-1:0]                digits;
        lcg = seed;
        for (int unsigned i = 0; i < spdd_pkg::DigitCount; i++)
            perm[i] = spdd_pkg::DigitWidth'(i);
        for (int unsigned i = 1; i < spdd_pkg::DigitCount; i++)
        begin
            lcg = offset_mirror + lcg * multiplier_mirror;
            pos = lcg % (i + 1);
            held = perm[i];
            perm[i] = perm[pos];
            perm[pos] = held;
        end
        for (int unsigned k = 0; k < spdd_pkg::PinLength; k++)
        begin
            // non-digit characters bypass the table
            if (chars[k] < spdd_pkg::CharZero || chars[k] > spdd_pkg::CharNine)
                digits[k] = '0;
            else
                digits[k] = perm[chars[k] - spdd_pkg::CharZero];
        end
        return pin_digits_t'{digit_first: digits[0], digit_second: digits[1],
                             digit_third: digits[2], digit_fourth: digits[3]};
    endfunction

    function automatic spdd_pkg::char_t random_char();
        if ($urandom_range(3) != 0)
            return spdd_pkg::char_t'(spdd_pkg::CharZero + $urandom_range(9));
        return spdd_pkg::char_t'($urandom_range(255));
    endfunction

    function automatic logic [spdd_pkg::SeedWidth-1:0] random_seed();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic compare_digit(input string field, input spdd_pkg::digit_t want,
                                 input spdd_pkg::digit_t got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            error_count++;
        end
    endtask

    // result side: receiver stalls, result checks and the watchdog
    always @(posedge clk)
    begin
        pin_digits_t want;
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (out_valid && out_ready)
        begin
            if (pending_digits.size() == 0)
            begin
                $error("result transfer with no pending pin");
                error_count++;
            end
            else
            begin
                want = pending_digits.pop_front();
                compare_digit("digit_first", want.digit_first, digit_first);
                compare_digit("digit_second", want.digit_second, digit_second);
                compare_digit("digit_third", want.digit_third, digit_third);
                compare_digit("digit_fourth", want.digit_fourth, digit_fourth);
                pins_checked++;
            end
        end
        if (quiet_cycles >= StallLimit)
        begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_pin(input logic [spdd_pkg::SeedWidth-1:0] seed,
                            input spdd_pkg::char_t c1, input spdd_pkg::char_t c2,
                            input spdd_pkg::char_t c3, input spdd_pkg::char_t c4);
        int gap;
        gap = 0;
        while (gap < MaxGap && $urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        session_seed <= seed;
        char_first   <= c1;
        char_second  <= c2;
        char_third   <= c3;
        char_fourth  <= c4;
        do
            @(posedge clk);
        while (!in_ready);
        pending_digits.push_back(unscramble_pin(seed, {c4, c3, c2, c1}));
        pins_sent++;
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_digits.size() != 0);
    endtask

    task automatic write_reg(input spdd_pkg::cfg_idx_t idx,
                             input logic [spdd_pkg::SeedWidth-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        case (idx)
            spdd_pkg::CFG_SEED_OFFSET:     offset_mirror = value;
            spdd_pkg::CFG_SEED_MULTIPLIER: multiplier_mirror = value;
            default: ;
        endcase
    endtask

    task automatic set_lcg(input logic [spdd_pkg::SeedWidth-1:0] offset,
                           input logic [spdd_pkg::SeedWidth-1:0] mult);
        wait_all_results();
        repeat (DrainCycles) @(posedge clk);
        write_reg(spdd_pkg::CFG_SEED_OFFSET, offset);
        write_reg(spdd_pkg::CFG_SEED_MULTIPLIER, mult);
        settings_used++;
    endtask

    task automatic run_random_pins(input int count);
        for (int n = 0; n < count; n++)
            send_pin(random_seed(), random_char(), random_char(), random_char(), random_char());
    endtask

    task automatic test_default_registers();
        send_pin('0, "0", "1", "2", "3");
        send_pin('0, "4", "5", "6", "7");
        send_pin('0, "8", "9", "0", "9");
        send_pin('1, "0", "1", "2", "3");
        send_pin('1, "4", "5", "6", "7");
        send_pin('1, "8", "9", "9", "0");
        send_pin(32'h1234_5678, "5", "5", "3", "1");
    endtask

    task automatic test_nondigit_chars();
        // just below and above the digit range, plus high ascii
        send_pin(32'hDEAD_BEEF, 8'h00, 8'hFF, 8'h2F, 8'h3A);
        send_pin(32'h0000_0001, 8'h80, 8'h7F, 8'h20, "5");
        send_pin(32'h8000_0000, "9", 8'h41, 8'hAF, 8'h39);
    endtask

    task automatic test_register_extremes();
        set_lcg('0, '0);
        send_pin(32'hCAFE_F00D, "0", "1", "2", "3");
        send_pin('1, "9", "8", "7", "6");
        set_lcg('1, '1);
        send_pin('0, "0", "1", "2", "3");
        send_pin('1, "4", "5", "6", "7");
        set_lcg('0, 32'h0000_0001);
        send_pin(32'h0000_0007, "8", "9", "0", "5");
        set_lcg('1, '0);
        send_pin(32'h5555_AAAA, "3", "9", "0", "1");
    endtask

    task automatic test_unthrottled();
        set_lcg(spdd_pkg::OffsetReset, spdd_pkg::MultiplierReset);
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        run_random_pins(235);
    endtask

    task automatic test_sender_gaps();
        set_lcg($urandom, $urandom);
        sender_idle_pct    = 60;
        receiver_stall_pct = 0;
        run_random_pins(120);
        // hold off until the pipeline is empty, then resume
        wait_all_results();
        run_random_pins(115);
    endtask

    task automatic test_receiver_stalls();
        set_lcg($urandom, '1);
        sender_idle_pct    = 0;
        receiver_stall_pct = 60;
        run_random_pins(235);
    endtask

    task automatic test_mixed_idling();
        set_lcg($urandom, $urandom);
        sender_idle_pct    = 8;
        receiver_stall_pct = 8;
        run_random_pins(235);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_registers();
        test_nondigit_chars();
        test_register_extremes();
        test_unthrottled();
        test_sender_gaps();
        test_receiver_stalls();
        test_mixed_idling();
        wait_all_results();
        repeat (DrainCycles) @(posedge clk);
        $display("sent %0d pins under %0d lcg settings, %0d results checked",
                 pins_sent, settings_used, pins_checked);
        $display("flow control: free running, sender gaps, receiver stalls, light mix");
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- files.f -----
sv/spdd_pkg.sv
sv/spdd_ctrl.sv
sv/spdd_datapath.sv
sv/scrambled_pin_digit_decoder_unit.sv
sv/spdd_checker.sv
tb/tb_top.sv
